// ===== rtl/fpmt_pkg.sv =====
// ----------------------------------------------------------------------------
// fpmt_pkg
// Shared types and constants of the prefix-maximum table.
// ----------------------------------------------------------------------------
package fpmt_pkg;

    // Table geometry
    localparam int ENTRIES = 1024;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // Walk index holds one bit more: an upward step may leave the table
    localparam int WALK_W  = ADDR_W + 1;

    // Field widths
    localparam int MODE_W  = 1;
    localparam int INDEX_W = 10;
    localparam int DATA_W  = 32;
    localparam int SIZE_W  = 11;

    // Width for comparisons against the active size and the table depth
    localparam int CMP_W   = (WALK_W > SIZE_W) ? WALK_W : SIZE_W;

    // Reset contents of every node and the start of a query's running maximum
    localparam logic signed [DATA_W-1:0] NODE_RESET = -32'sd1;

    // Reset value of the active size
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_UPDATE = 1'b0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    // One step of a tree walk
    typedef struct packed {
        logic [WALK_W-1:0] nxt;
        logic              go;
    } walk_step_t;

endpackage

// ===== rtl/fpmt_walk.sv =====
// ----------------------------------------------------------------------------
// fpmt_walk
// Next-node logic of the tree walk: upward for updates, downward for queries.
// ----------------------------------------------------------------------------
module fpmt_walk
(
    input  logic [fpmt_pkg::WALK_W-1:0] cur,
    input  logic                        query,
    input  logic [fpmt_pkg::CMP_W-1:0]  limit,
    output fpmt_pkg::walk_step_t        step
);

    logic [fpmt_pkg::WALK_W-1:0] inc;
    logic [fpmt_pkg::WALK_W-1:0] up;
    logic [fpmt_pkg::WALK_W-1:0] down;

    assign inc  = cur + fpmt_pkg::WALK_W'(1);
    assign up   = cur | inc;
    assign down = cur & inc;

    // Pick the covering node above, or the next disjoint range below
    always_comb
    begin
        if (query)
        begin
            step.nxt = down - fpmt_pkg::WALK_W'(1);
            step.go  = (down != '0);
        end
        else
        begin
            step.nxt = up;
            step.go  = (fpmt_pkg::CMP_W'(up) < limit);
        end
    end

endmodule

// ===== rtl/fenwick_prefix_max_table_top.sv =====
// ----------------------------------------------------------------------------
// fenwick_prefix_max_table_top
// Binary indexed tree of running maxima with update and prefix query.
// ----------------------------------------------------------------------------
//  channel | signals                          | transaction
//  --------+----------------------------------+------------------------------
//  input   | in_valid, in_stall, mode,        | one update or one query
//          | index, value                     |
//  output  | out_valid, out_stall, prefix_max | one query result
//  config  | cfg_valid, cfg_ready, cfg_data   | write of active_size
//
//  One node is read per cycle from a one-port-read, one-port-write memory;
//  the compare and write-back follow in the cycle after each read. An
//  update with an index at or beyond the active size reaches no node;
//  a query ends by loading its result into the output register.
//  After reset a clearing pass writes -1 to all ENTRIES nodes, one per
//  cycle; no input is taken meanwhile, configuration is.
//  A waiting result does not block the next input transaction; a query
//  holds only when the previous result has not yet been taken.
// ----------------------------------------------------------------------------
module fenwick_prefix_max_table_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fpmt_pkg::MODE_W-1:0]         mode,
    input  logic [fpmt_pkg::INDEX_W-1:0]        index,
    input  logic signed [fpmt_pkg::DATA_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [fpmt_pkg::DATA_W-1:0]  prefix_max,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fpmt_pkg::SIZE_W-1:0]         cfg_data
);

    // Node memory
    logic signed [fpmt_pkg::DATA_W-1:0] node_mem [fpmt_pkg::ENTRIES];
    logic signed [fpmt_pkg::DATA_W-1:0] rdata_reg;
    logic                               mem_re;
    logic [fpmt_pkg::ADDR_W-1:0]        mem_raddr;
    logic                               mem_we;
    logic [fpmt_pkg::ADDR_W-1:0]        mem_waddr;
    logic signed [fpmt_pkg::DATA_W-1:0] mem_wdata;

    // Control and walk registers
    fpmt_pkg::state_t                   state_reg, state_next;
    logic [fpmt_pkg::ADDR_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [fpmt_pkg::SIZE_W-1:0]        size_reg;
    logic [fpmt_pkg::WALK_W-1:0]        rd_i_reg, rd_i_next;
    logic                               rd_go_reg, rd_go_next;
    logic                               p_valid_reg, p_valid_next;
    logic [fpmt_pkg::ADDR_W-1:0]        p_addr_reg, p_addr_next;
    logic                               query_reg, query_next;
    logic signed [fpmt_pkg::DATA_W-1:0] value_reg, value_next;
    logic signed [fpmt_pkg::DATA_W-1:0] best_reg, best_next;
    logic                               out_valid_reg, out_valid_next;
    logic signed [fpmt_pkg::DATA_W-1:0] out_data_reg, out_data_next;

    logic [fpmt_pkg::CMP_W-1:0]         limit;
    logic [fpmt_pkg::CMP_W-1:0]         qidx;
    logic [fpmt_pkg::CMP_W-1:0]         uidx;
    logic                               in_take;
    fpmt_pkg::walk_step_t               step;

    // Clamp the active size to the table depth
    always_comb
    begin
        if (fpmt_pkg::CMP_W'(size_reg) > fpmt_pkg::CMP_W'(fpmt_pkg::ENTRIES))
            limit = fpmt_pkg::CMP_W'(fpmt_pkg::ENTRIES);
        else
            limit = fpmt_pkg::CMP_W'(size_reg);
    end

    // Saturate the query start to the last entry
    always_comb
    begin
        uidx = fpmt_pkg::CMP_W'(index);
        if (uidx >= fpmt_pkg::CMP_W'(fpmt_pkg::ENTRIES))
            qidx = fpmt_pkg::CMP_W'(fpmt_pkg::ENTRIES - 1);
        else
            qidx = uidx;
    end

    fpmt_walk u_walk
    (
        .cur   (rd_i_reg),
        .query (query_reg),
        .limit (limit),
        .step  (step)
    );

    assign in_stall   = (state_reg != fpmt_pkg::ST_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign prefix_max = out_data_reg;

    // Next state, walk sequencing and memory controls
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        rd_i_next      = rd_i_reg;
        rd_go_next     = rd_go_reg;
        p_valid_next   = 1'b0;
        p_addr_next    = p_addr_reg;
        query_next     = query_reg;
        value_next     = value_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_re         = 1'b0;
        mem_raddr      = rd_i_reg[fpmt_pkg::ADDR_W-1:0];
        mem_we         = 1'b0;
        mem_waddr      = p_addr_reg;
        mem_wdata      = value_reg;

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            fpmt_pkg::ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = fpmt_pkg::NODE_RESET;
                clr_cnt_next = clr_cnt_reg + fpmt_pkg::ADDR_W'(1);
                if (clr_cnt_reg == fpmt_pkg::ADDR_W'(fpmt_pkg::ENTRIES - 1))
                    state_next = fpmt_pkg::ST_IDLE;
            end
            fpmt_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    query_next = (mode == fpmt_pkg::MODE_QUERY);
                    value_next = value;
                    best_next  = fpmt_pkg::NODE_RESET;
                    if (mode == fpmt_pkg::MODE_QUERY)
                    begin
                        rd_i_next  = fpmt_pkg::WALK_W'(qidx);
                        rd_go_next = 1'b1;
                    end
                    else
                    begin
                        rd_i_next  = fpmt_pkg::WALK_W'(uidx);
                        rd_go_next = (uidx < limit);
                    end
                    state_next = fpmt_pkg::ST_WALK;
                end
            end
            fpmt_pkg::ST_WALK:
            begin
                // Issue the read of the current node and advance
                if (rd_go_reg)
                begin
                    mem_re       = 1'b1;
                    p_valid_next = 1'b1;
                    p_addr_next  = rd_i_reg[fpmt_pkg::ADDR_W-1:0];
                    rd_i_next    = step.nxt;
                    rd_go_next   = step.go;
                end
                // Merge the node read in the previous cycle
                if (p_valid_reg)
                begin
                    if (query_reg)
                    begin
                        if (rdata_reg > best_reg)
                            best_next = rdata_reg;
                    end
                    else if (value_reg > rdata_reg)
                    begin
                        mem_we = 1'b1;
                    end
                end
                if (!rd_go_reg && !p_valid_reg)
                begin
                    if (query_reg)
                        state_next = fpmt_pkg::ST_DONE;
                    else
                        state_next = fpmt_pkg::ST_IDLE;
                end
            end
            fpmt_pkg::ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = best_reg;
                    state_next     = fpmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpmt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpmt_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            size_reg      <= fpmt_pkg::SIZE_RESET;
            rd_go_reg     <= 1'b0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rd_go_reg     <= rd_go_next;
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                size_reg <= cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_i_reg     <= rd_i_next;
        p_addr_reg   <= p_addr_next;
        query_reg    <= query_next;
        value_reg    <= value_next;
        best_reg     <= best_next;
        out_data_reg <= out_data_next;
    end

    // Node memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            node_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= node_mem[mem_raddr];
    end

endmodule
